### rtl/ednm_pkg.sv
package ednm_pkg;

   // table and descriptor geometry
   localparam int CAPACITY   = 256;
   localparam int DESCR_LEN  = 128;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = $clog2(DESCR_LEN);
   localparam int POSC_W     = $clog2(DESCR_LEN + 1);
   localparam int CAND_DEPTH = CAPACITY * DESCR_LEN;
   localparam int ADDR_W     = $clog2(CAND_DEPTH);

   // field widths
   localparam int ACT_W  = 2;
   localparam int ROW_W  = 14;
   localparam int ELEM_W = 8;
   localparam int LIM_W  = 8;
   localparam int DIST_W = 23;
   localparam int SQ_W   = 2 * ELEM_W;

   // packed channel widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = DIST_W;

   // distance bounds
   localparam longint FULL_SUM = longint'(DESCR_LEN) * 64'd65025;
   localparam longint DIST_CAP = (64'd1 << DIST_W) - 64'd1;
   localparam int ACC_W = $clog2(FULL_SUM + 1);
   localparam logic [DIST_W-1:0] DIST_MAX =
      DIST_W'((FULL_SUM > DIST_CAP) ? DIST_CAP : FULL_SUM);

   // register reset values
   localparam logic [LIM_W-1:0]  EPI_LIMIT_RST = LIM_W'(6);
   localparam logic [DIST_W-1:0] MAX_DIST_RST  = DIST_W'(90000);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EPI_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST  = 1'b1;

   // item kinds
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CAND  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL_C,
      ST_FILL_Q,
      ST_SINIT,
      ST_ROW,
      ST_CHK,
      ST_DIST,
      ST_DRAIN,
      ST_CMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear_tbl;
      logic take_cand;
      logic take_query;
      logic fill_cand;
      logic fill_query;
      logic search_init;
      logic acc_clr;
      logic issue;
      logic cmp;
      logic next_cand;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             last;
      logic             fill_need;
      logic             pos_last;
      logic             cand_full;
      logic             count_zero;
      logic             row_ok;
      logic             issue_last;
      logic             pipe_busy;
      logic             last_cand;
      logic             rsp_full;
   } dp_sts_type;

endpackage

### rtl/epipolar_descriptor_nearest_match_top.sv
// Nearest descriptor match under an epipolar row window.
// The req channel carries one descriptor element per item; tuser selects
// clear table, candidate element or query element, tlast closes a feature.
// Candidates are stored in load order; a feature that ends early has its
// remaining elements zeroed by a fill pass of one element per cycle,
// during which req_tready is low.
// After the last element of a query the table is searched and one result
// item goes out on rsp: found flag in tuser, index and squared distance in
// tdata. The search checks each candidate against the row window and, for
// one inside it, reads one descriptor byte a cycle from the single
// candidate memory read port, then lets the pipeline drain; last of all
// the result register is loaded.
// The result register lets the next item be taken while a result waits;
// a further search stalls at its end until rsp_tready frees the register.
// The csr channel is always ready: index 0 epipolar limit, 1 max distance.
// Reset clears the count, position and registers to their defaults; the
// descriptor stores are not cleared and need no time after reset.
module epipolar_descriptor_nearest_match_top
   import ednm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req tdata: row_pos, elem_value, zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req tuser: action
   input  logic [ACT_W-1:0]      req_tuser,
   input  logic                  req_tlast,
   // rsp tdata: best_index, best_dist_sq, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp tuser: found
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   ednm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // stores, distance pipeline and result register
   ednm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/ednm_ctrl.sv
module ednm_ctrl
   import ednm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       rsp_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && sts.last) begin
               if (sts.action == ACT_CAND && !sts.cand_full && sts.fill_need) begin
                  state_in = ST_FILL_C;
               end else if (sts.action == ACT_QUERY) begin
                  state_in = sts.fill_need ? ST_FILL_Q : ST_SINIT;
               end
            end
         end
         ST_FILL_C: begin
            if (sts.pos_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_FILL_Q: begin
            if (sts.pos_last) begin
               state_in = ST_SINIT;
            end
         end
         ST_SINIT: begin
            state_in = sts.count_zero ? ST_OUT : ST_ROW;
         end
         ST_ROW: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (sts.row_ok) begin
               state_in = ST_DIST;
            end else begin
               state_in = sts.last_cand ? ST_OUT : ST_ROW;
            end
         end
         ST_DIST: begin
            if (sts.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = sts.last_cand ? ST_OUT : ST_ROW;
         end
         ST_OUT: begin
            if (!sts.rsp_full || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (sts.action == ACT_CLEAR) begin
                  cmd.clear_tbl = 1'b1;
               end else if (sts.action == ACT_CAND) begin
                  cmd.take_cand = !sts.cand_full;
               end else if (sts.action == ACT_QUERY) begin
                  cmd.take_query = 1'b1;
               end else begin
               end
            end
         end
         ST_FILL_C: begin
            cmd.fill_cand = 1'b1;
         end
         ST_FILL_Q: begin
            cmd.fill_query = 1'b1;
         end
         ST_SINIT: begin
            cmd.search_init = 1'b1;
         end
         ST_ROW: begin
         end
         ST_CHK: begin
            cmd.acc_clr   = sts.row_ok;
            cmd.next_cand = !sts.row_ok;
         end
         ST_DIST: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_CMP: begin
            cmd.cmp       = 1'b1;
            cmd.next_cand = 1'b1;
         end
         ST_OUT: begin
            cmd.load_rsp = !sts.rsp_full || rsp_tready;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/ednm_dpath.sv
module ednm_dpath
   import ednm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACT_W-1:0]      req_tuser,
   input  logic                  req_tlast,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   // item fields
   logic [ROW_W-1:0]  in_row;
   logic [ELEM_W-1:0] in_val;

   // stores
   logic [ELEM_W-1:0] cand_mem  [CAND_DEPTH];
   logic [ROW_W-1:0]  row_mem   [CAPACITY];
   logic [ELEM_W-1:0] query_mem [DESCR_LEN];

   // control state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [POSC_W-1:0] pos_ff, pos_in;
   logic [ROW_W-1:0]  qrow_ff, qrow_in;
   logic [LIM_W-1:0]  epi_ff, epi_in;
   logic [DIST_W-1:0] maxd_ff, maxd_in;
   logic [IDX_W-1:0]  cand_ff, cand_in;
   logic [POS_W-1:0]  elem_ff, elem_in;
   logic              v1_ff, v2_ff, v3_ff;

   // search datapath
   logic [ROW_W-1:0]  rowq_ff;
   logic [ELEM_W-1:0] cd_ff, qd_ff;
   logic [ELEM_W-1:0] ad_ff, ad_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  bidx_ff, bidx_in;
   logic              any_ff, any_in;
   logic [DIST_W-1:0] dist_now;
   logic [ROW_W-1:0]  row_diff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic                  rsp_found_ff, rsp_found_in;

   // helpers
   logic              pos_lt;
   logic              fill_need;
   logic              pos_last;
   logic [POSC_W-1:0] pos_step;
   logic [IDX_W-1:0]  slot;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              cand_we;
   logic              query_we;
   logic [ELEM_W-1:0] wr_val;

   assign in_row = req_tdata[ROW_W-1:0];
   assign in_val = req_tdata[ROW_W+ELEM_W-1:ROW_W];

   assign pos_lt    = pos_ff < POSC_W'(DESCR_LEN);
   assign fill_need = pos_ff < POSC_W'(DESCR_LEN - 1);
   assign pos_last  = pos_ff == POSC_W'(DESCR_LEN - 1);
   assign pos_step  = pos_ff + POSC_W'(pos_lt);
   assign slot      = count_ff[IDX_W-1:0];

   // element position and table count
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      priority if (cmd.clear_tbl) begin
         pos_in   = '0;
         count_in = '0;
      end else if (cmd.take_cand || cmd.take_query) begin
         if (req_tlast && !fill_need) begin
            pos_in = '0;
            if (cmd.take_cand) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            pos_in = pos_step;
         end
      end else if (cmd.fill_cand || cmd.fill_query) begin
         if (pos_last) begin
            pos_in = '0;
            if (cmd.fill_cand) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            pos_in = pos_ff + POSC_W'(1);
         end
      end else begin
      end
   end

   // query row and registers
   always_comb begin
      qrow_in = cmd.take_query ? in_row : qrow_ff;
      epi_in  = epi_ff;
      maxd_in = maxd_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_EPI_LIMIT: epi_in  = csr_data[LIM_W-1:0];
            CSR_MAX_DIST:  maxd_in = csr_data[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // store writes and search reads
   assign cand_we  = (cmd.take_cand && pos_lt) || cmd.fill_cand;
   assign query_we = (cmd.take_query && pos_lt) || cmd.fill_query;
   assign wr_val   = (cmd.fill_cand || cmd.fill_query) ? '0 : in_val;
   assign wr_addr  = ADDR_W'(slot) * ADDR_W'(DESCR_LEN) + ADDR_W'(pos_ff[POS_W-1:0]);
   assign rd_addr  = ADDR_W'(cand_ff) * ADDR_W'(DESCR_LEN) + ADDR_W'(elem_ff);

   always_ff @(posedge clock) begin
      if (cand_we) begin
         cand_mem[wr_addr] <= wr_val;
      end
      cd_ff <= cand_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (query_we) begin
         query_mem[pos_ff[POS_W-1:0]] <= wr_val;
      end
      qd_ff <= query_mem[elem_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_cand) begin
         row_mem[slot] <= in_row;
      end
      rowq_ff <= row_mem[cand_ff];
   end

   // candidate and element counters
   always_comb begin
      cand_in = cand_ff;
      elem_in = elem_ff;
      if (cmd.search_init) begin
         cand_in = '0;
      end else if (cmd.next_cand) begin
         cand_in = cand_ff + IDX_W'(1);
      end
      if (cmd.acc_clr) begin
         elem_in = '0;
      end else if (cmd.issue) begin
         elem_in = elem_ff + POS_W'(1);
      end
   end

   // difference, square, accumulate
   assign ad_in = (qd_ff > cd_ff) ? (qd_ff - cd_ff) : (cd_ff - qd_ff);
   assign sq_in = SQ_W'(ad_ff) * SQ_W'(ad_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (v3_ff) begin
         acc_in = acc_ff + ACC_W'(sq_ff);
      end
   end

   assign dist_now = (acc_ff > ACC_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(acc_ff);

   // running best
   always_comb begin
      best_in = best_ff;
      bidx_in = bidx_ff;
      any_in  = any_ff;
      if (cmd.search_init) begin
         best_in = DIST_MAX;
         bidx_in = '0;
         any_in  = 1'b0;
      end else if (cmd.cmp && (!any_ff || dist_now < best_ff)) begin
         best_in = dist_now;
         bidx_in = cand_ff;
         any_in  = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_found_in = rsp_found_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = any_ff ? bidx_ff : '0;
         rsp_dist_in  = best_ff;
         rsp_found_in = any_ff && (best_ff <= maxd_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         qrow_ff      <= '0;
         epi_ff       <= EPI_LIMIT_RST;
         maxd_ff      <= MAX_DIST_RST;
         cand_ff      <= '0;
         elem_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         qrow_ff      <= qrow_in;
         epi_ff       <= epi_in;
         maxd_ff      <= maxd_in;
         cand_ff      <= cand_in;
         elem_ff      <= elem_in;
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ad_ff        <= ad_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      best_ff      <= best_in;
      bidx_ff      <= bidx_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_found_ff <= rsp_found_in;
   end

   // epipolar row window
   assign row_diff = (qrow_ff > rowq_ff) ? (qrow_ff - rowq_ff) : (rowq_ff - qrow_ff);

   // status
   always_comb begin
      sts            = '0;
      sts.action     = req_tuser;
      sts.last       = req_tlast;
      sts.fill_need  = fill_need;
      sts.pos_last   = pos_last;
      sts.cand_full  = count_ff >= CNT_W'(CAPACITY);
      sts.count_zero = count_ff == '0;
      sts.row_ok     = row_diff <= ROW_W'(epi_ff);
      sts.issue_last = elem_ff == POS_W'(DESCR_LEN - 1);
      sts.pipe_busy  = v1_ff || v2_ff || v3_ff;
      sts.last_cand  = (CNT_W'(cand_ff) + CNT_W'(1)) == count_ff;
      sts.rsp_full   = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - IDX_W - DIST_W){1'b0}}, rsp_dist_ff, rsp_idx_ff};

endmodule
